// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on clk, switched off while rst is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

   localparam int POOL_BITS   = 21;
   localparam int SIZE_BITS   = 20;
   localparam int DADDR_BITS  = 20;
   localparam int STATUS_BITS = 2;

   localparam logic [POOL_BITS-1:0] POOL_RESET = 21'd65536;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NO_FIT   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_BAD_FREE = 2'd2;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_HINT_RD,
      DP_HINT_CUR,
      DP_SCAN_START,
      DP_SCAN_NEXT,
      DP_GRANT,
      DP_SH_RD,
      DP_SH_WR,
      DP_SPLIT,
      DP_F_RD,
      DP_F_NEXT,
      DP_F_HIT,
      DP_LO_STEP,
      DP_HI_STEP,
      DP_C_INIT,
      DP_C_RD,
      DP_C_WR,
      DP_F_DONE,
      DP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic [STATUS_BITS-1:0] code;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic small_pool;
      logic hint_ok;
      logic fit;
      logic split_ok;
      logic last;
      logic sh_more;
      logic f_match;
      logic lo_more;
      logic hi_more;
      logic c_more;
   } dp_status_type;

endpackage

// ===== rtl/ffha_ram.sv =====
module ffha_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/ffha_ctrl.sv =====
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffha_pkg::dp_status_type stat,
   output ffha_pkg::dp_cmd_type    cmd
);
   import ffha_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_HINT_CUR, S_CHECK, S_SH_TEST, S_SH_WR,
      S_F_CHK, S_LO, S_HI, S_C_TEST, S_C_WR, S_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic                   hint_mode_ff, hint_mode_in;
   logic [STATUS_BITS-1:0] code_ff, code_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      hint_mode_in = hint_mode_ff;
      code_in      = code_ff;
      cmd.op       = DP_NOP;
      cmd.code     = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = DP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            hint_mode_in = 1'b0;
            if (stat.is_free) begin
               cmd.op   = DP_F_RD;
               state_in = S_F_CHK;
            end else if (stat.small_pool) begin
               code_in  = ST_NO_FIT;
               state_in = S_RESP;
            end else if (stat.hint_ok) begin
               cmd.op       = DP_HINT_RD;
               hint_mode_in = 1'b1;
               state_in     = S_HINT_CUR;
            end else begin
               cmd.op   = DP_SCAN_START;
               state_in = S_CHECK;
            end
         end
         S_HINT_CUR: begin
            cmd.op   = DP_HINT_CUR;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.fit) begin
               cmd.op  = DP_GRANT;
               code_in = ST_OK;
               // without a split the grant is complete
               state_in = stat.split_ok ? S_SH_TEST : S_RESP;
            end else if (hint_mode_ff) begin
               cmd.op       = DP_SCAN_START;
               hint_mode_in = 1'b0;
            end else if (stat.last) begin
               code_in  = ST_NO_FIT;
               state_in = S_RESP;
            end else begin
               cmd.op = DP_SCAN_NEXT;
            end
         end
         S_SH_TEST: begin
            if (stat.sh_more) begin
               cmd.op   = DP_SH_RD;
               state_in = S_SH_WR;
            end else begin
               cmd.op   = DP_SPLIT;
               state_in = S_RESP;
            end
         end
         S_SH_WR: begin
            cmd.op   = DP_SH_WR;
            state_in = S_SH_TEST;
         end
         S_F_CHK: begin
            if (stat.f_match) begin
               cmd.op   = DP_F_HIT;
               state_in = S_LO;
            end else if (stat.last) begin
               code_in  = ST_BAD_FREE;
               state_in = S_RESP;
            end else begin
               cmd.op = DP_F_NEXT;
            end
         end
         S_LO: begin
            if (stat.lo_more) begin
               cmd.op = DP_LO_STEP;
            end else begin
               state_in = S_HI;
            end
         end
         S_HI: begin
            if (stat.hi_more) begin
               cmd.op = DP_HI_STEP;
            end else begin
               cmd.op   = DP_C_INIT;
               state_in = S_C_TEST;
            end
         end
         S_C_TEST: begin
            if (stat.c_more) begin
               cmd.op   = DP_C_RD;
               state_in = S_C_WR;
            end else begin
               cmd.op   = DP_F_DONE;
               code_in  = ST_OK;
               state_in = S_RESP;
            end
         end
         S_C_WR: begin
            cmd.op   = DP_C_WR;
            state_in = S_C_TEST;
         end
         S_RESP: begin
            cmd.op   = DP_RESP;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hint_mode_ff <= 1'b0;
         code_ff      <= ST_OK;
      end else begin
         state_ff     <= state_in;
         hint_mode_ff <= hint_mode_in;
         code_ff      <= code_in;
      end
   end
endmodule

// ===== rtl/ffha_dp.sv =====
module ffha_dp #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int ADDRESS_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ffha_pkg::dp_cmd_type                cmd,
   output ffha_pkg::dp_status_type             stat,
   input  logic                                req_operation,
   input  logic [ffha_pkg::SIZE_BITS-1:0]      req_request_bytes,
   input  logic [ffha_pkg::DADDR_BITS-1:0]     req_release_address,
   input  logic                                csr_wr_en,
   input  logic [ffha_pkg::POOL_BITS-1:0]      csr_wr_data,
   output logic                                rsp_valid,
   output logic [ffha_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [ffha_pkg::DADDR_BITS-1:0]     rsp_data_address
);
   import ffha_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int IW = $clog2(MAX_BLOCKS + 1);
   localparam int CW = ((ADDRESS_BITS > POOL_BITS) ? ADDRESS_BITS : POOL_BITS) + 2;
   localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] LIM = CW'(1) << ADDRESS_BITS;
   localparam logic [IW-1:0] MAXC = IW'(MAX_BLOCKS);

   logic [POOL_BITS-1:0]    pool_ff, pool_in;
   logic [MAX_BLOCKS-1:0]   used_ff, used_in;
   logic [IW-1:0]           count_ff, count_in;
   logic [IW-1:0]           hint_ff, hint_in;
   logic                    hint_v_ff, hint_v_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           j_ff, j_in;
   logic [IW-1:0]           lo_ff, lo_in;
   logic [IW-1:0]           hi_ff, hi_in;
   logic [ADDRESS_BITS-1:0] cur_ff, cur_in;
   logic [SIZE_BITS-1:0]    size_ff, size_in;
   logic [DADDR_BITS-1:0]   addr_ff, addr_in;
   logic                    op_ff, op_in;
   logic                    rv_ff, rv_in;
   logic [STATUS_BITS-1:0]  rs_ff, rs_in;
   logic [DADDR_BITS-1:0]   ra_ff, ra_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [ADDRESS_BITS-1:0] wr_data, rd_data;

   logic [CW-1:0] pool_w, psize, endm, cur_w, nxt_w, ds, size_w, s_w;
   logic [IW-1:0] idx_p1, gap;
   logic [IW:0]   j_gap;

   ffha_ram #(.WIDTH(ADDRESS_BITS), .DEPTH(MAX_BLOCKS)) u_start_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      pool_w = CW'(pool_ff);
      psize  = (pool_w > LIM) ? LIM : pool_w;
      endm   = (psize >= HDR) ? psize - HDR : '0;
      idx_p1 = idx_ff + IW'(1);
      gap    = hi_ff - lo_ff;
      j_gap  = {1'b0, j_ff} + {1'b0, gap};
      cur_w  = CW'(cur_ff);
      nxt_w  = (idx_p1 < count_ff) ? CW'(rd_data) : endm;
      ds     = (nxt_w >= cur_w + HDR) ? nxt_w - cur_w - HDR : '0;
      size_w = CW'(size_ff);
      s_w    = (idx_ff == '0) ? '0 : CW'(rd_data);

      stat.is_free    = op_ff;
      stat.small_pool = psize < (HDR << 1);
      stat.hint_ok    = hint_v_ff && (hint_ff < count_ff) && !used_ff[hint_ff[AW-1:0]];
      stat.fit        = !used_ff[idx_ff[AW-1:0]] && (ds >= size_w);
      stat.split_ok   = (ds > size_w + HDR) && (count_ff < MAXC);
      stat.last       = idx_p1 >= count_ff;
      stat.sh_more    = j_ff > idx_p1;
      stat.f_match    = used_ff[idx_ff[AW-1:0]] && (s_w + HDR == CW'(addr_ff));
      stat.lo_more    = (lo_ff != '0) && !used_ff[AW'(lo_ff - IW'(1))];
      stat.hi_more    = (hi_ff + IW'(1) < count_ff) && !used_ff[AW'(hi_ff + IW'(1))];
      stat.c_more     = (gap != '0) && (j_gap < {1'b0, count_ff});
   end

   always_comb begin
      pool_in  = pool_ff;
      used_in  = used_ff;
      count_in = count_ff;
      hint_in  = hint_ff;
      hint_v_in = hint_v_ff;
      idx_in   = idx_ff;
      j_in     = j_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      cur_in   = cur_ff;
      size_in  = size_ff;
      addr_in  = addr_ff;
      op_in    = op_ff;
      rv_in    = 1'b0;
      rs_in    = rs_ff;
      ra_in    = ra_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_p1[AW-1:0];
      case (cmd.op)
         DP_LOAD: begin
            op_in   = req_operation;
            size_in = req_request_bytes;
            addr_in = req_release_address;
            idx_in  = '0;
            cur_in  = '0;
         end
         DP_HINT_RD: begin
            idx_in  = hint_ff;
            rd_addr = hint_ff[AW-1:0];
         end
         DP_HINT_CUR: begin
            cur_in = (idx_ff == '0) ? '0 : rd_data;
         end
         DP_SCAN_START: begin
            idx_in  = '0;
            cur_in  = '0;
            rd_addr = AW'(1);
         end
         DP_SCAN_NEXT: begin
            cur_in  = ADDRESS_BITS'(nxt_w);
            idx_in  = idx_p1;
            rd_addr = AW'(idx_ff + IW'(2));
         end
         DP_GRANT: begin
            used_in[idx_ff[AW-1:0]] = 1'b1;
            j_in = count_ff;
         end
         DP_SH_RD: begin
            rd_addr = AW'(j_ff - IW'(1));
         end
         DP_SH_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            used_in[j_ff[AW-1:0]] = used_ff[AW'(j_ff - IW'(1))];
            j_in    = j_ff - IW'(1);
         end
         DP_SPLIT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_p1[AW-1:0];
            wr_data  = ADDRESS_BITS'(cur_w + HDR + size_w);
            used_in[idx_p1[AW-1:0]] = 1'b0;
            count_in = count_ff + IW'(1);
            if (hint_v_ff && hint_ff > idx_ff) begin
               hint_in = hint_ff + IW'(1);
            end
         end
         DP_F_RD: begin
            rd_addr = idx_ff[AW-1:0];
         end
         DP_F_NEXT: begin
            idx_in = idx_p1;
         end
         DP_F_HIT: begin
            used_in[idx_ff[AW-1:0]] = 1'b0;
            lo_in = idx_ff;
            hi_in = idx_ff;
         end
         DP_LO_STEP: lo_in = lo_ff - IW'(1);
         DP_HI_STEP: hi_in = hi_ff + IW'(1);
         DP_C_INIT:  j_in = lo_ff + IW'(1);
         DP_C_RD: begin
            rd_addr = j_gap[AW-1:0];
         end
         DP_C_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            used_in[j_ff[AW-1:0]] = used_ff[j_gap[AW-1:0]];
            j_in    = j_ff + IW'(1);
         end
         DP_F_DONE: begin
            count_in  = count_ff - gap;
            hint_in   = lo_ff;
            hint_v_in = 1'b1;
         end
         DP_RESP: begin
            rv_in = 1'b1;
            rs_in = cmd.code;
            ra_in = (cmd.code == ST_OK && op_ff == OP_ALLOC)
                  ? DADDR_BITS'(cur_w + HDR) : '0;
         end
         default: ;
      endcase
      if (cmd.op == DP_F_NEXT) begin
         rd_addr = idx_p1[AW-1:0];
      end
      if (csr_wr_en) begin
         pool_in   = csr_wr_data;
         used_in   = '0;
         count_in  = IW'(1);
         hint_in   = '0;
         hint_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff   <= POOL_RESET;
         used_ff   <= '0;
         count_ff  <= IW'(1);
         hint_ff   <= '0;
         hint_v_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         pool_ff   <= pool_in;
         used_ff   <= used_in;
         count_ff  <= count_in;
         hint_ff   <= hint_in;
         hint_v_ff <= hint_v_in;
         rv_ff     <= rv_in;
      end
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      cur_ff  <= cur_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      op_ff   <= op_in;
      rs_ff   <= rs_in;
      ra_ff   <= ra_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_status       = rs_ff;
   assign rsp_data_address = ra_ff;
endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing over one byte pool. Raise start
// with a word on the req_ ports while busy is low; the word is taken at that
// edge and busy stays high until the answer is ready. The answer appears on
// the rsp_ ports for exactly one cycle, marked by rsp_valid, in the cycle in
// which busy has just dropped, and cannot be held off: sample it then. An
// allocate without a usable reuse hint runs the first-fit search over the
// table (a failed one examines every entry); a tiny pool fails without a
// search. An allocate that fits the reuse hint needs no search; a hint that
// does not fit is followed by the search. A split moves entries up one by
// one to open a slot for the new entry. A free searches the table for the
// address, merges free neighbours and moves entries down when merged blocks
// are removed; an unknown address walks every table entry. Busy time is set
// by the walk over the block start table RAM, which has one read and one
// write port. Write csr_wr_data (pool size) only while idle; a write also
// empties the table.
module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 16,
   parameter int ADDRESS_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [ffha_pkg::SIZE_BITS-1:0]   req_request_bytes,
   input  logic [ffha_pkg::DADDR_BITS-1:0]  req_release_address,
   output logic                             rsp_valid,
   output logic [ffha_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [ffha_pkg::DADDR_BITS-1:0]  rsp_data_address,
   input  logic                             csr_wr_en,
   input  logic [ffha_pkg::POOL_BITS-1:0]   csr_wr_data
);
   import ffha_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   // sequence the walk: decide, search, split or merge, answer
   ffha_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .stat (stat),
      .cmd  (cmd)
   );

   // hold the table, pool size, hint and the answer word
   ffha_dp #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .HEADER_BYTES(HEADER_BYTES),
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_request_bytes  (req_request_bytes),
      .req_release_address(req_release_address),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_data_address   (rsp_data_address)
   );
endmodule

// ===== rtl/ffha_checker.sv =====
`include "assert_macros.svh"

module ffha_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [ffha_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [ffha_pkg::DADDR_BITS-1:0]  rsp_data_address
);
   import ffha_pkg::*;

   `ASSERT_CLK_RST(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accept without busy")
   `ASSERT_CLK_RST(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "answer longer than one cycle")
   `ASSERT_CLK_RST(a_rsp_idle, clock, reset, $fell(busy) |-> rsp_valid, "busy dropped without answer")
   `ASSERT_CLK_RST(a_fail_zero, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> (rsp_data_address == '0), "failed word carries address")
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_data_address(rsp_data_address)
);
